>>> rtl/core/tach_pkg.sv
// Shared types and constants for the tachometer rpm moving-average unit.
// No dependencies; every other file of the unit refers to this package by scoped names.
package tach_pkg;

	// Field widths of the channels and registers.
	localparam int DATA_W   = 32;
	localparam int ACTION_W = 2;
	localparam int PPR_W    = 8;
	localparam int TICK_W   = 23;

	// Configuration port.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 23;
	localparam logic [CFG_IDX_W-1:0] CFG_PULSES_PER_REV = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE_HZ   = 1'd1;

	// Register reset values.
	localparam logic [PPR_W-1:0]  PPR_RESET  = 8'd1;
	localparam logic [TICK_W-1:0] TICK_RESET = 23'd93750;

	// Action codes of an input word.
	localparam logic [ACTION_W-1:0] ACT_CAPTURE = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_RESTART = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_STOP    = 2'd2;

	// Bringing the speed back from milli-units: for any 32-bit x,
	// x / 1000 equals (x * RPM_RECIP) >> RPM_SHIFT.
	localparam int                 RECIP_W   = 29;
	localparam logic [RECIP_W-1:0] RPM_RECIP = 29'd274877907;
	localparam int                 RPM_SHIFT = 38;

endpackage

>>> rtl/core/tach_if.sv
// Channel interfaces of the tachometer unit: capture/command words in, speed words out.
// Depends on tach_pkg for the field widths.
interface tach_evt_if;
	logic                          valid;
	logic                          ready;
	logic [tach_pkg::ACTION_W-1:0] action;
	logic                          status_pending;
	logic [tach_pkg::DATA_W-1:0]   capture_first;
	logic [tach_pkg::DATA_W-1:0]   capture_second;

	modport source (output valid, action, status_pending, capture_first, capture_second,
		input ready);
	modport sink (input valid, action, status_pending, capture_first, capture_second,
		output ready);
endinterface

interface tach_res_if;
	logic                        valid;
	logic                        ready;
	logic                        handled;
	logic                        revolution_done;
	logic [tach_pkg::DATA_W-1:0] rpm_average;

	modport source (output valid, handled, revolution_done, rpm_average, input ready);
	modport sink (input valid, handled, revolution_done, rpm_average, output ready);
endinterface

>>> rtl/core/tachometer_rpm_moving_average_unit.sv
// Tachometer rpm moving-average unit: period measurement, rpm conversion, averaging ring.
// Depends on tach_pkg, tach_evt_if / tach_res_if and the shared divider tach_div.
//
// Usage: the evt channel carries one capture event or command word (capture, restart,
// stop); every accepted word returns exactly one word on the res channel holding the
// handled flag, the revolution-done flag and the current averaged rpm.
// Registers pulses_per_rev and tick_rate_hz are written through cfg_wr_en, cfg_index
// and cfg_data; the user writes them only while the unit is idle, which it does not enforce.
// Sequence: commands, ignored events and captures that do not end a revolution with a
// nonzero period go straight to the done state and the output register. A capture that
// ends a revolution runs a pass of the shared one-bit-per-cycle divider (dividend width
// SUM_W = 32 + clog2(FILTER_DEPTH)), the division by 1000, a sum over the filled ring
// entries, a second divider pass for the average and the hand-off through the done state
// to the output register.
// Throughput: one word at a time; evt.ready is high only while the sequencer is idle, so
// the next word can be accepted at the earliest in the same cycle in which the result appears.
// A finished result sits in the output register while the next word is accepted;
// if the receiver stalls, the unit holds its next result in the done state.
// Reset: pulses_per_rev 1, tick_rate_hz 93750, ring empty, average 0, measuring enabled.
module tachometer_rpm_moving_average_unit #(
	parameter int FILTER_DEPTH = 5
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [tach_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tach_pkg::CFG_DATA_W-1:0] cfg_data,
	tach_evt_if.sink                        evt,
	tach_res_if.source                      res
);
	localparam int DATA_W = tach_pkg::DATA_W;
	localparam int SUM_W  = DATA_W + $clog2(FILTER_DEPTH);
	localparam int CNT_W  = $clog2(FILTER_DEPTH + 1);
	localparam int IDX_W  = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
	localparam int PROD_W = DATA_W + tach_pkg::RECIP_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV1  = 3'd1;
	localparam logic [2:0] ST_SCALE = 3'd2;
	localparam logic [2:0] ST_SUM   = 3'd3;
	localparam logic [2:0] ST_AVG   = 3'd4;
	localparam logic [2:0] ST_DIV3  = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]                  state_q;
	logic [tach_pkg::PPR_W-1:0]  ppr_q;
	logic [tach_pkg::TICK_W-1:0] tick_q;
	logic [tach_pkg::PPR_W-1:0]  pulse_cnt_q;
	logic [DATA_W-1:0]           rev_start_q;
	logic [DATA_W-1:0]           ring_q [FILTER_DEPTH];
	logic [IDX_W-1:0]            ring_idx_q;
	logic [CNT_W-1:0]            fill_q;
	logic [CNT_W-1:0]            sum_idx_q;
	logic [SUM_W-1:0]            sum_q;
	logic [DATA_W-1:0]           avg_q;
	logic [DATA_W-1:0]           scale_q;
	logic                        running_q;
	logic                        handled_q;
	logic                        rev_done_q;
	logic                        res_valid_q;
	logic                        res_handled_q;
	logic                        res_done_q;
	logic [DATA_W-1:0]           res_rpm_q;

	logic                        accept;
	logic                        is_capture;
	logic [tach_pkg::PPR_W-1:0]  pulse_next;
	logic                        rev_end;
	logic [DATA_W-1:0]           end_time;
	logic [DATA_W-1:0]           period;
	logic [DATA_W-1:0]           tick_milli;
	logic [DATA_W-1:0]           div_low;
	logic [DATA_W-1:0]           rpm_milli;
	logic [PROD_W-1:0]           scale_prod;
	logic [DATA_W-1:0]           rpm_val;
	logic                        load_res;

	logic                        div_start;
	logic [SUM_W-1:0]            div_dividend;
	logic [DATA_W-1:0]           div_divisor;
	logic                        div_busy;
	logic                        div_done;
	logic [SUM_W-1:0]            div_quo;

	// Capture decode: pulse step and end-of-revolution test by pulses_per_rev parity.
	always_comb begin
		accept     = evt.valid && evt.ready;
		is_capture = (evt.action == tach_pkg::ACT_CAPTURE) && evt.status_pending && running_q;
		pulse_next = pulse_cnt_q + (ppr_q[0] ? tach_pkg::PPR_W'(1) : tach_pkg::PPR_W'(2));
		rev_end    = (pulse_next >= ppr_q);
		end_time   = ppr_q[0] ? evt.capture_first : evt.capture_second;
		period     = end_time - rev_start_q;
	end

	// Constant scalings by shift and add: tick * 1000 and quotient * 60, both modulo 2^32.
	always_comb begin
		tick_milli = (DATA_W'(tick_q) << 10) - (DATA_W'(tick_q) << 4) - (DATA_W'(tick_q) << 3);
		div_low    = div_quo[DATA_W-1:0];
		rpm_milli  = (div_low << 6) - (div_low << 2);
	end

	// Division of the registered milli-rpm value by 1000 through its reciprocal.
	always_comb begin
		scale_prod = PROD_W'(scale_q) * PROD_W'(tach_pkg::RPM_RECIP);
		rpm_val    = DATA_W'(scale_prod >> tach_pkg::RPM_SHIFT);
	end

	// Operand selection for the shared divider.
	always_comb begin
		div_start    = 1'b0;
		div_dividend = SUM_W'(tick_milli);
		div_divisor  = period;
		unique case (state_q)
			ST_IDLE: begin
				div_start = accept && is_capture && rev_end && (period != '0);
			end
			ST_AVG: begin
				div_start    = 1'b1;
				div_dividend = sum_q;
				div_divisor  = DATA_W'(fill_q);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	tach_div #(
		.DVD_W (SUM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign evt.ready = (state_q == ST_IDLE);
	assign load_res  = (state_q == ST_DONE) && (!res_valid_q || res.ready);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppr_q  <= tach_pkg::PPR_RESET;
			tick_q <= tach_pkg::TICK_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				tach_pkg::CFG_PULSES_PER_REV: ppr_q  <= cfg_data[tach_pkg::PPR_W-1:0];
				tach_pkg::CFG_TICK_RATE_HZ:   tick_q <= cfg_data[tach_pkg::TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer: decode, rpm division and scaling, ring sum, average division, hand-off.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pulse_cnt_q <= '0;
			rev_start_q <= '0;
			ring_idx_q  <= '0;
			fill_q      <= '0;
			sum_idx_q   <= '0;
			sum_q       <= '0;
			avg_q       <= '0;
			scale_q     <= '0;
			running_q   <= 1'b1;
			handled_q   <= 1'b0;
			rev_done_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						handled_q  <= is_capture;
						rev_done_q <= 1'b0;
						if (is_capture && rev_end && (period != '0)) begin
							state_q <= ST_DIV1;
						end else begin
							state_q <= ST_DONE;
						end
						if (is_capture) begin
							if (!rev_end) begin
								pulse_cnt_q <= pulse_next;
							end else begin
								pulse_cnt_q <= '0;
								rev_start_q <= end_time;
							end
						end else if (evt.action == tach_pkg::ACT_RESTART) begin
							ring_idx_q  <= '0;
							fill_q      <= '0;
							pulse_cnt_q <= '0;
							running_q   <= 1'b1;
						end else if (evt.action == tach_pkg::ACT_STOP) begin
							running_q <= 1'b0;
						end
					end
				end
				ST_DIV1: begin
					if (div_done) begin
						scale_q <= rpm_milli;
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					ring_idx_q <= (ring_idx_q == IDX_W'(FILTER_DEPTH - 1)) ? '0
						: ring_idx_q + IDX_W'(1);
					if (fill_q != CNT_W'(FILTER_DEPTH)) begin
						fill_q <= fill_q + CNT_W'(1);
					end
					sum_idx_q <= '0;
					sum_q     <= '0;
					state_q   <= ST_SUM;
				end
				ST_SUM: begin
					sum_q     <= sum_q + SUM_W'(ring_q[sum_idx_q[IDX_W-1:0]]);
					sum_idx_q <= sum_idx_q + CNT_W'(1);
					if (sum_idx_q == fill_q - CNT_W'(1)) begin
						state_q <= ST_AVG;
					end
				end
				ST_AVG: begin
					state_q <= ST_DIV3;
				end
				ST_DIV3: begin
					if (div_done) begin
						avg_q      <= div_low;
						rev_done_q <= 1'b1;
						state_q    <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_res) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Ring storage: the new speed goes in once it is scaled back from milli-units.
	always_ff @(posedge clk) begin
		if (state_q == ST_SCALE) begin
			ring_q[ring_idx_q] <= rpm_val;
		end
	end

	// Output word register.
	always_ff @(posedge clk) begin
		if (load_res) begin
			res_handled_q <= handled_q;
			res_done_q    <= rev_done_q;
			res_rpm_q     <= avg_q;
		end
	end

	assign res.valid           = res_valid_q;
	assign res.handled         = res_handled_q;
	assign res.revolution_done = res_done_q;
	assign res.rpm_average     = res_rpm_q;

`ifndef SYNTHESIS
	// A completed revolution is always a handled capture.
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (!res.revolution_done || res.handled))
		else $error("revolution_done without handled");

	// The divider is only started when it is free.
	assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	// The fill count never passes the ring depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(FILTER_DEPTH))
		else $error("fill count beyond ring depth");

	// An accepted word always takes the sequencer out of idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ST_IDLE))
		else $error("accepted word did not start the sequencer");
`endif
endmodule

>>> rtl/core/tach_div.sv
// Shared restoring divider of the tachometer unit: one quotient bit per clock cycle.
// Depends on tach_pkg for the divisor width.
module tach_div #(
	parameter int DVD_W = 35
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [DVD_W-1:0]            dividend,
	input  logic [tach_pkg::DATA_W-1:0] divisor,
	output logic                        busy,
	output logic                        done,
	output logic [DVD_W-1:0]            quotient
);
	localparam int DVS_W = tach_pkg::DATA_W;
	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W+1:0] diff;
	logic             fits;

	// One restoring step: shift in the next dividend bit and try the subtraction.
	always_comb begin
		trial = {rem_q, quo_q[DVD_W-1]};
		diff  = {1'b0, trial} - {2'b00, dvs_q};
		fits  = ~diff[DVS_W+1];
	end

	// Step counter and status.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNT_W'(DVD_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Partial remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;
endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the tachometer rpm moving-average unit.
// Depends on tach_pkg, tach_evt_if / tach_res_if and the unit's top module from the RTL.
// An in-bench predictor derives every speed word, and a receiver process checks it.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FILTER_DEPTH = 5;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int DATA_W = tach_pkg::DATA_W;
	localparam int ACTION_W = tach_pkg::ACTION_W;
	localparam int PPR_W = tach_pkg::PPR_W;
	localparam int TICK_W = tach_pkg::TICK_W;
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
	localparam logic [TICK_W-1:0] TICK_MAX = 23'd4294967;

	typedef struct packed {
		logic              handled;
		logic              revolution_done;
		logic [DATA_W-1:0] rpm_average;
	} speed_word_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [tach_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [tach_pkg::CFG_DATA_W-1:0] cfg_data;

	tach_evt_if evt_ch ();
	tach_res_if res_ch ();

	tachometer_rpm_moving_average_unit #(
		.FILTER_DEPTH(FILTER_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.evt      (evt_ch),
		.res      (res_ch)
	);

	// Predicted register and measurement state.
	logic [PPR_W-1:0]  ppr_reg;
	logic [TICK_W-1:0] tick_reg;
	logic [PPR_W-1:0]  pulse_cnt;
	logic [DATA_W-1:0] rev_start;
	logic [DATA_W-1:0] speed_hist [FILTER_DEPTH];
	int                hist_wr;
	int                hist_fill;
	logic [DATA_W-1:0] avg_rpm;
	logic              meas_on;

	speed_word_t expected_speed_q [$];
	int error_count = 0;
	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	int cycle_count = 0;

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Run limit.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	// Clears the speed history and the pulse count, as a restart does.
	task automatic clear_history();
		for (int i = 0; i < FILTER_DEPTH; i++) speed_hist[i] = '0;
		hist_wr = 0;
		hist_fill = 0;
		pulse_cnt = '0;
	endtask

	// Works out the speed word that one accepted input word produces.
	task automatic predict_speed_word(input logic [ACTION_W-1:0] act, input logic pend,
		input logic [DATA_W-1:0] cap1, input logic [DATA_W-1:0] cap2);
		speed_word_t w;
		logic [DATA_W-1:0] end_t, period, scaled, quo, rpm;
		logic [63:0] sum;
		w.handled = 1'b0;
		w.revolution_done = 1'b0;
		case (act)
			tach_pkg::ACT_CAPTURE: begin
				if (pend && meas_on) begin
					w.handled = 1'b1;
					pulse_cnt = pulse_cnt + (ppr_reg[0] ? 8'd1 : 8'd2);
					if (pulse_cnt >= ppr_reg) begin
						end_t = ppr_reg[0] ? cap1 : cap2;
						period = end_t - rev_start;
						rev_start = end_t;
						if (period != '0) begin
							scaled = 32'(tick_reg) * 32'd1000;
							quo = scaled / period;
							rpm = (quo * 32'd60) / 32'd1000;
							speed_hist[hist_wr] = rpm;
							hist_wr = (hist_wr + 1) % FILTER_DEPTH;
							if (hist_fill < FILTER_DEPTH) hist_fill++;
							sum = '0;
							for (int i = 0; i < hist_fill; i++) sum += 64'(speed_hist[i]);
							avg_rpm = 32'(sum / 64'(hist_fill));
							w.revolution_done = 1'b1;
						end
						pulse_cnt = '0;
					end
				end
			end
			tach_pkg::ACT_RESTART: begin
				clear_history();
				meas_on = 1'b1;
			end
			tach_pkg::ACT_STOP: begin
				meas_on = 1'b0;
			end
			default: begin
			end
		endcase
		w.rpm_average = avg_rpm;
		expected_speed_q.push_back(w);
	endtask

	// Sends one input word, with a random idle gap before it.
	task automatic send_word(input logic [ACTION_W-1:0] act, input logic pend,
		input logic [DATA_W-1:0] cap1, input logic [DATA_W-1:0] cap2);
		if ($urandom_range(99) < src_idle_pct) begin
			evt_ch.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < src_idle_pct) @(posedge clk);
		end
		evt_ch.valid <= 1'b1;
		evt_ch.action <= act;
		evt_ch.status_pending <= pend;
		evt_ch.capture_first <= cap1;
		evt_ch.capture_second <= cap2;
		@(posedge clk);
		while (!evt_ch.ready) @(posedge clk);
		predict_speed_word(act, pend, cap1, cap2);
	endtask

	// Sends a pending capture whose revolution-ending register holds end_t.
	task automatic send_capture(input logic [DATA_W-1:0] end_t);
		if (ppr_reg[0]) send_word(tach_pkg::ACT_CAPTURE, 1'b1, end_t, $urandom);
		else send_word(tach_pkg::ACT_CAPTURE, 1'b1, $urandom, end_t);
	endtask

	// Lowers valid and waits until every predicted word has come back.
	task automatic drain_results();
		evt_ch.valid <= 1'b0;
		while (expected_speed_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes both registers; only called while the unit is idle.
	task automatic write_regs(input logic [PPR_W-1:0] ppr, input logic [TICK_W-1:0] tick);
		cfg_wr_en <= 1'b1;
		cfg_index <= tach_pkg::CFG_PULSES_PER_REV;
		cfg_data <= tach_pkg::CFG_DATA_W'(ppr);
		@(posedge clk);
		ppr_reg = ppr;
		cfg_index <= tach_pkg::CFG_TICK_RATE_HZ;
		cfg_data <= tick;
		@(posedge clk);
		tick_reg = tick;
		cfg_wr_en <= 1'b0;
	endtask

	// Captures at the reset setting: normal, spurious, zero period, rollover, ring wrap.
	task automatic test_capture_basics();
		send_word(tach_pkg::ACT_CAPTURE, 1'b1, 32'd1000, $urandom);
		send_word(tach_pkg::ACT_CAPTURE, 1'b0, 32'd5, 32'd7);
		send_word(tach_pkg::ACT_CAPTURE, 1'b1, 32'd2000, 32'hFFFF_FFFF);
		send_word(tach_pkg::ACT_CAPTURE, 1'b1, 32'd2000, 32'd0);
		send_word(tach_pkg::ACT_CAPTURE, 1'b1, 32'hFFFF_FFFF, 32'd0);
		send_word(tach_pkg::ACT_CAPTURE, 1'b1, 32'h0000_0010, 32'hFFFF_FFFF);
		send_word(tach_pkg::ACT_CAPTURE, 1'b1, 32'h0000_0011, $urandom);
		send_word(tach_pkg::ACT_CAPTURE, 1'b1, 32'd517, $urandom);
		send_word(tach_pkg::ACT_CAPTURE, 1'b1, 32'd1217, $urandom);
		drain_results();
	endtask

	// Stop, capture while stopped, the unused code, restart and a fresh ring.
	task automatic test_commands();
		send_word(tach_pkg::ACT_STOP, 1'b0, 32'd0, 32'd0);
		send_word(tach_pkg::ACT_CAPTURE, 1'b1, rev_start + 32'd100, 32'd0);
		send_word(ACT_UNUSED, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(tach_pkg::ACT_RESTART, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(tach_pkg::ACT_CAPTURE, 1'b1, rev_start + 32'd3000, 32'd0);
		send_word(tach_pkg::ACT_CAPTURE, 1'b1, 32'd0, 32'd0);
		drain_results();
	endtask

	// Even pulse counts use the second register; a count of zero ends every event.
	task automatic test_even_parity();
		write_regs(8'd4, TICK_MAX);
		send_word(tach_pkg::ACT_CAPTURE, 1'b1, 32'hFFFF_FFFF, 32'd0);
		send_capture(rev_start + 32'd7);
		send_capture(rev_start + 32'd1);
		send_capture(rev_start + 32'd1);
		drain_results();
		write_regs(8'd0, 23'd1);
		send_capture(rev_start + 32'd1);
		send_capture(rev_start + 32'd1000);
		send_capture(rev_start);
		drain_results();
	endtask

	// Picks a revolution end time: mostly a log-spread period, some zero, some anything.
	function automatic logic [DATA_W-1:0] pick_end_time();
		logic [DATA_W-1:0] span;
		span = $urandom >> $urandom_range(31);
		if (span == '0) span = 32'd1;
		if ($urandom_range(19) == 0) span = '0;
		if ($urandom_range(9) == 0) return $urandom;
		return rev_start + span;
	endfunction

	// One block of random words at one register setting.
	task automatic run_block(input logic [PPR_W-1:0] ppr, input logic [TICK_W-1:0] tick,
		input int n_words);
		int cmd_pm;
		int r;
		write_regs(ppr, tick);
		// Long revolutions need a quiet command stream to ever complete.
		cmd_pm = (ppr > 8'd16) ? 2 : 35;
		for (int k = 0; k < n_words; k++) begin
			r = $urandom_range(999);
			if (!meas_on && $urandom_range(2) == 0)
				send_word(tach_pkg::ACT_RESTART, 1'($urandom), $urandom, $urandom);
			else if (r < cmd_pm)
				send_word(tach_pkg::ACT_RESTART, 1'($urandom), $urandom, $urandom);
			else if (r < 2 * cmd_pm)
				send_word(tach_pkg::ACT_STOP, 1'($urandom), $urandom, $urandom);
			else if (r < 2 * cmd_pm + 20)
				send_word(ACT_UNUSED, 1'($urandom), $urandom, $urandom);
			else if (r < 2 * cmd_pm + 80)
				send_word(tach_pkg::ACT_CAPTURE, 1'b0, $urandom, $urandom);
			else send_capture(pick_end_time());
		end
		drain_results();
	endtask

	// Random words under three idle profiles and a range of settings.
	task automatic test_random();
		src_idle_pct = 9;
		sink_idle_pct = 65;
		run_block(8'd1, tach_pkg::TICK_RESET, 120);
		run_block(8'd2, TICK_MAX, 120);
		run_block(8'd255, 23'($urandom_range(4294967, 1)), 500);
		src_idle_pct = 65;
		sink_idle_pct = 9;
		run_block(8'd0, 23'd1, 120);
		run_block(8'd3, 23'd1000000, 120);
		run_block(8'd4, 23'($urandom_range(4294967, 1)), 120);
		src_idle_pct = 0;
		sink_idle_pct = 0;
		run_block(8'($urandom_range(16, 1)), TICK_MAX, 120);
		run_block(8'd254, 23'd1, 500);
		run_block(8'd5, 23'($urandom_range(4294967, 1)), 120);
	endtask

	// Compares one received speed word with the oldest prediction.
	task automatic check_speed_word();
		speed_word_t w;
		if (expected_speed_q.size() == 0) begin
			$error("speed word received with none expected");
			error_count++;
		end else begin
			w = expected_speed_q.pop_front();
			if (res_ch.handled !== w.handled) begin
				$error("handled: expected %0d, actual %0d", w.handled, res_ch.handled);
				error_count++;
			end
			if (res_ch.revolution_done !== w.revolution_done) begin
				$error("revolution_done: expected %0d, actual %0d", w.revolution_done,
					res_ch.revolution_done);
				error_count++;
			end
			if (res_ch.rpm_average !== w.rpm_average) begin
				$error("rpm_average: expected %0d, actual %0d", w.rpm_average,
					res_ch.rpm_average);
				error_count++;
			end
		end
	endtask

	// Receiver: checks each accepted word and stalls at random.
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_ch.valid && res_ch.ready) check_speed_word();
			res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// Main sequence.
	initial begin
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= tach_pkg::CFG_PULSES_PER_REV;
		cfg_data <= '0;
		evt_ch.valid <= 1'b0;
		evt_ch.action <= tach_pkg::ACT_CAPTURE;
		evt_ch.status_pending <= 1'b0;
		evt_ch.capture_first <= '0;
		evt_ch.capture_second <= '0;
		ppr_reg = tach_pkg::PPR_RESET;
		tick_reg = tach_pkg::TICK_RESET;
		clear_history();
		rev_start = '0;
		avg_rpm = '0;
		meas_on = 1'b1;
		src_idle_pct = 9;
		sink_idle_pct = 65;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_capture_basics();
		test_commands();
		test_even_parity();
		test_random();
		repeat (30) @(posedge clk);
		if (error_count == 0 && expected_speed_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/core/tach_pkg.sv
rtl/core/tach_if.sv
rtl/core/tach_div.sv
rtl/core/tachometer_rpm_moving_average_unit.sv
tb/tb_top.sv
